### src/gda_pkg.sv
// shared types, constants and calendar helpers for the gregorian date unit
package gda_pkg;

  localparam int unsigned DW           = 25;
  localparam int unsigned YW           = 16;
  localparam int unsigned RW           = 9;
  localparam int unsigned DIFF_W       = 22;
  localparam int unsigned MAX_YEAR_DEF = 9999;

  localparam logic [DW-1:0] CYCLE_DAYS  = DW'(146097);
  localparam logic [YW-1:0] CYCLE_YEARS = YW'(400);
  localparam logic [RW-1:0] CYCLE_LAST  = RW'(399);
  localparam logic [DIFF_W-1:0] DIFF_MAX = {DIFF_W{1'b1}};

  localparam logic [2:0] OP_VALIDATE = 3'd0;
  localparam logic [2:0] OP_INC      = 3'd1;
  localparam logic [2:0] OP_ADD      = 3'd2;
  localparam logic [2:0] OP_SUB      = 3'd3;
  localparam logic [2:0] OP_DIFF     = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FIRST_BAD  = 3'd1;
  localparam logic [2:0] ST_SECOND_BAD = 3'd2;
  localparam logic [2:0] ST_RANGE      = 3'd3;
  localparam logic [2:0] ST_EARLIER    = 3'd4;

  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_NOV = 4'd11;
  localparam logic [3:0] MON_DEC = 4'd12;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [4:0]  first_day;
    logic [3:0]  first_month;
    logic [13:0] first_year;
    logic [4:0]  second_day;
    logic [3:0]  second_month;
    logic [13:0] second_year;
    logic [15:0] step_days;
  } gda_in_t;

  typedef struct packed {
    logic [2:0]        result_status;
    logic [4:0]        result_day;
    logic [3:0]        result_month;
    logic [13:0]       result_year;
    logic [DIFF_W-1:0] day_difference;
  } gda_out_t;

  // leap test from the year modulo 400
  function automatic logic leap_of(input logic [RW-1:0] r);
    return (r[1:0] == 2'd0) && (r != RW'(100)) && (r != RW'(200)) && (r != RW'(300));
  endfunction

  function automatic logic [4:0] month_days(input logic lp, input logic [3:0] m);
    logic [4:0] n;
    n = 5'd31;
    if (m == MON_FEB) begin
      n = lp ? 5'd29 : 5'd28;
    end else if ((m == MON_APR) || (m == MON_JUN) || (m == MON_SEP) || (m == MON_NOV)) begin
      n = 5'd30;
    end
    return n;
  endfunction

  function automatic logic [RW-1:0] year_days(input logic lp);
    return lp ? RW'(366) : RW'(365);
  endfunction

  function automatic logic [RW-1:0] cyc_inc(input logic [RW-1:0] r);
    return (r == CYCLE_LAST) ? '0 : r + RW'(1);
  endfunction

  function automatic logic [RW-1:0] cyc_dec(input logic [RW-1:0] r);
    return (r == '0) ? CYCLE_LAST : r - RW'(1);
  endfunction

endpackage

### src/gda_alu.sv
// shared add/subtract unit for the date sequencer
module gda_alu (
  input  logic [gda_pkg::DW-1:0] a,
  input  logic [gda_pkg::DW-1:0] b,
  input  logic                   sub,
  output logic [gda_pkg::DW-1:0] res
);
  import gda_pkg::*;

  assign res = sub ? (a - b) : (a + b);

endmodule

### src/gregorian_date_arithmetic_top.sv
// gregorian date unit: validate, add or subtract days, day difference
//
// one request enters on the in_ channel (in_valid/in_ready) as a packed
// gda_in_t; exactly one gda_out_t comes back on the out_ channel
// (out_valid/out_ready). in_ready is high only while the sequencer is idle,
// so one request is worked at a time.
// a single add/subtract unit is stepped by the sequencer: the year is
// reduced modulo 400 in 6 steps, months are summed one per cycle, and
// years are walked one per cycle (whole 400-year cycles in one step for
// the difference). an add or subtract crosses at most 180 years.
// the finished result sits in an output register; a new request may be
// taken while it waits, and the next result holds in the sequencer until
// the receiver takes the pending one.
// reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_valid; no memory needs clearing.
module gregorian_date_arithmetic_top #(
  parameter int unsigned MAX_YEAR = gda_pkg::MAX_YEAR_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gda_pkg::gda_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output gda_pkg::gda_out_t out_data
);
  import gda_pkg::*;

  localparam logic [YW-1:0] MAX_Y = YW'(MAX_YEAR);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_MOD  = 12'b000000000010,
    S_CHK  = 12'b000000000100,
    S_DOY  = 12'b000000001000,
    S_STEP = 12'b000000010000,
    S_YADD = 12'b000000100000,
    S_YSUB = 12'b000001000000,
    S_MON  = 12'b000010000000,
    S_DSUB = 12'b000100000000,
    S_D400 = 12'b001000000000,
    S_DYR  = 12'b010000000000,
    S_DONE = 12'b100000000000
  } state_t;

  state_t            state_r, state_nxt;
  gda_in_t           req_r, req_nxt;
  logic              sel_r, sel_nxt;
  logic [2:0]        k_r, k_nxt;
  logic [DW-1:0]     rem_r, rem_nxt;
  logic [RW-1:0]     r1_r, r1_nxt;
  logic [RW-1:0]     r2_r, r2_nxt;
  logic [RW-1:0]     r4_r, r4_nxt;
  logic [3:0]        mon_r, mon_nxt;
  logic [DW-1:0]     acc_r, acc_nxt;
  logic [RW-1:0]     doy_r, doy_nxt;
  logic [YW-1:0]     y_r, y_nxt;
  logic [2:0]        st_r, st_nxt;
  logic [4:0]        rd_r, rd_nxt;
  logic [3:0]        rm_r, rm_nxt;
  logic [13:0]       ry_r, ry_nxt;
  logic [DIFF_W-1:0] df_r, df_nxt;
  gda_out_t          out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [DW-1:0] alu_a, alu_b, alu_res;
  logic          alu_sub, alu_neg;

  logic [4:0]    d_cur;
  logic [3:0]    m_cur;
  logic          lp_rem, lp_cur, lp_prev, date_ok;
  logic [YW-1:0] y1e, y2e, gap;
  logic [RW-1:0] r4_prev;

  gda_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  assign alu_neg = alu_res[DW-1];

  always_comb begin
    d_cur   = sel_r ? req_r.second_day : req_r.first_day;
    m_cur   = sel_r ? req_r.second_month : req_r.first_month;
    lp_rem  = leap_of(rem_r[RW-1:0]);
    lp_cur  = leap_of(r4_r);
    r4_prev = cyc_dec(r4_r);
    lp_prev = leap_of(r4_prev);
    date_ok = (m_cur >= 4'd1) && (m_cur <= MON_DEC) && (d_cur >= 5'd1) &&
              (d_cur <= month_days(lp_rem, m_cur));
    y1e     = YW'(req_r.first_year);
    y2e     = YW'(req_r.second_year);
    gap     = y1e - y_r;
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    sel_nxt       = sel_r;
    k_nxt         = k_r;
    rem_nxt       = rem_r;
    r1_nxt        = r1_r;
    r2_nxt        = r2_r;
    r4_nxt        = r4_r;
    mon_nxt       = mon_r;
    acc_nxt       = acc_r;
    doy_nxt       = doy_r;
    y_nxt         = y_r;
    st_nxt        = st_r;
    rd_nxt        = rd_r;
    rm_nxt        = rm_r;
    ry_nxt        = ry_r;
    df_nxt        = df_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    alu_a         = acc_r;
    alu_b         = '0;
    alu_sub       = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          sel_nxt   = 1'b0;
          rem_nxt   = DW'(in_data.first_year);
          k_nxt     = 3'd5;
          st_nxt    = ST_OK;
          rd_nxt    = in_data.first_day;
          rm_nxt    = in_data.first_month;
          ry_nxt    = in_data.first_year;
          df_nxt    = '0;
          state_nxt = S_MOD;
        end
      end

      // restoring reduction of the year by 400
      S_MOD: begin
        alu_a   = rem_r;
        alu_b   = DW'(400) << k_r;
        alu_sub = 1'b1;
        if (!alu_neg) begin
          rem_nxt = alu_res;
        end
        k_nxt = k_r - 3'd1;
        if (k_r == 3'd0) begin
          state_nxt = S_CHK;
        end
      end

      S_CHK: begin
        if (!sel_r) begin
          r1_nxt = rem_r[RW-1:0];
          if (!date_ok) begin
            st_nxt    = ST_FIRST_BAD;
            state_nxt = S_DONE;
          end else if ((req_r.req_type == OP_INC) || (req_r.req_type == OP_ADD) ||
                       (req_r.req_type == OP_SUB)) begin
            mon_nxt   = 4'd1;
            acc_nxt   = DW'(req_r.first_day) - DW'(1);
            y_nxt     = y1e;
            r4_nxt    = rem_r[RW-1:0];
            state_nxt = S_DOY;
          end else if (req_r.req_type == OP_DIFF) begin
            sel_nxt   = 1'b1;
            rem_nxt   = DW'(req_r.second_year);
            k_nxt     = 3'd5;
            state_nxt = S_MOD;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          r2_nxt = rem_r[RW-1:0];
          if (!date_ok) begin
            st_nxt    = ST_SECOND_BAD;
            state_nxt = S_DONE;
          end else if ((y1e > MAX_Y) || (y2e > MAX_Y)) begin
            st_nxt    = ST_RANGE;
            state_nxt = S_DONE;
          end else if (y1e < y2e) begin
            st_nxt    = ST_EARLIER;
            state_nxt = S_DONE;
          end else begin
            mon_nxt   = 4'd1;
            acc_nxt   = DW'(req_r.second_day) - DW'(1);
            r4_nxt    = rem_r[RW-1:0];
            state_nxt = S_DOY;
          end
        end
      end

      // day of year: sum the months before the target month
      S_DOY: begin
        if (mon_r == m_cur) begin
          if (req_r.req_type == OP_DIFF) begin
            if (sel_r) begin
              doy_nxt = acc_r[RW-1:0];
              sel_nxt = 1'b0;
              r4_nxt  = r1_r;
              mon_nxt = 4'd1;
              acc_nxt = DW'(req_r.first_day) - DW'(1);
            end else begin
              state_nxt = S_DSUB;
            end
          end else begin
            state_nxt = S_STEP;
          end
        end else begin
          alu_b   = DW'(month_days(lp_cur, mon_r));
          acc_nxt = alu_res;
          mon_nxt = mon_r + 4'd1;
        end
      end

      S_STEP: begin
        if (req_r.req_type == OP_INC) begin
          alu_b = DW'(1);
        end else begin
          alu_b = DW'(req_r.step_days);
        end
        alu_sub = (req_r.req_type == OP_SUB);
        acc_nxt = alu_res;
        state_nxt = (req_r.req_type == OP_SUB) ? S_YSUB : S_YADD;
      end

      S_YADD: begin
        alu_b   = DW'(year_days(lp_cur));
        alu_sub = 1'b1;
        if (!alu_neg) begin
          acc_nxt = alu_res;
          y_nxt   = y_r + YW'(1);
          r4_nxt  = cyc_inc(r4_r);
        end else begin
          mon_nxt   = 4'd1;
          state_nxt = S_MON;
        end
      end

      S_YSUB: begin
        alu_b = DW'(year_days(lp_prev));
        if (!acc_r[DW-1]) begin
          mon_nxt   = 4'd1;
          state_nxt = S_MON;
        end else if (y_r == '0) begin
          st_nxt    = ST_RANGE;
          state_nxt = S_DONE;
        end else begin
          acc_nxt = alu_res;
          y_nxt   = y_r - YW'(1);
          r4_nxt  = r4_prev;
        end
      end

      S_MON: begin
        alu_b   = DW'(month_days(lp_cur, mon_r));
        alu_sub = 1'b1;
        if (!alu_neg && (mon_r < MON_DEC)) begin
          acc_nxt = alu_res;
          mon_nxt = mon_r + 4'd1;
        end else begin
          if ((y_r == '0) || (y_r > MAX_Y)) begin
            st_nxt = ST_RANGE;
          end else begin
            rd_nxt = acc_r[4:0] + 5'd1;
            rm_nxt = mon_r;
            ry_nxt = y_r[13:0];
          end
          state_nxt = S_DONE;
        end
      end

      S_DSUB: begin
        alu_b   = DW'(doy_r);
        alu_sub = 1'b1;
        acc_nxt = alu_res;
        y_nxt   = y2e;
        r4_nxt  = r2_r;
        if ((y1e == y2e) && alu_neg) begin
          st_nxt    = ST_EARLIER;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_D400;
        end
      end

      S_D400: begin
        alu_b = CYCLE_DAYS;
        if (gap >= CYCLE_YEARS) begin
          acc_nxt = alu_res;
          y_nxt   = y_r + CYCLE_YEARS;
        end else begin
          state_nxt = S_DYR;
        end
      end

      S_DYR: begin
        alu_b = DW'(year_days(lp_cur));
        if (y_r == y1e) begin
          if (|acc_r[DW-2:DIFF_W]) begin
            df_nxt = DIFF_MAX;
          end else begin
            df_nxt = acc_r[DIFF_W-1:0];
          end
          state_nxt = S_DONE;
        end else begin
          acc_nxt = alu_res;
          y_nxt   = y_r + YW'(1);
          r4_nxt  = cyc_inc(r4_r);
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.result_status  = st_r;
          out_nxt.result_day     = rd_r;
          out_nxt.result_month   = rm_r;
          out_nxt.result_year    = ry_r;
          out_nxt.day_difference = df_r;
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    sel_r <= sel_nxt;
    k_r   <= k_nxt;
    rem_r <= rem_nxt;
    r1_r  <= r1_nxt;
    r2_r  <= r2_nxt;
    r4_r  <= r4_nxt;
    mon_r <= mon_nxt;
    acc_r <= acc_nxt;
    doy_r <= doy_nxt;
    y_r   <= y_nxt;
    st_r  <= st_nxt;
    rd_r  <= rd_nxt;
    rm_r  <= rm_nxt;
    ry_r  <= ry_nxt;
    df_r  <= df_nxt;
    out_r <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### dv/tb_gregorian_date_arithmetic_top.sv
// self-checking testbench for the gregorian date unit with a calendar predictor and scoreboard
import gda_pkg::*;

class date_scoreboard;
  gda_out_t    pending_results[$];
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned op_count[8];
  int unsigned status_count[8];

  static function bit leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  static function int unsigned days_in_month(int unsigned m, int unsigned y);
    if (m == MON_FEB) begin
      return leap_year(y) ? 29 : 28;
    end
    if ((m == MON_APR) || (m == MON_JUN) || (m == MON_SEP) || (m == MON_NOV)) begin
      return 30;
    end
    return 31;
  endfunction

  static function bit real_date(int unsigned d, int unsigned m, int unsigned y);
    if ((m < 1) || (m > MON_DEC)) begin
      return 1'b0;
    end
    return (d >= 1) && (d <= days_in_month(m, y));
  endfunction

  // days in all years ahead of y, year zero counted as leap
  static function int unsigned year_start(int unsigned y);
    int unsigned p;
    if (y == 0) begin
      return 0;
    end
    p = y - 1;
    return 365 * y + p / 4 - p / 100 + p / 400 + 1;
  endfunction

  static function int unsigned day_number(int unsigned d, int unsigned m, int unsigned y);
    int unsigned s;
    s = year_start(y);
    for (int unsigned k = 1; k < m; k++) begin
      s += days_in_month(k, y);
    end
    return s + d - 1;
  endfunction

  static function void split_day_number(input int unsigned s, output int unsigned d,
                                        output int unsigned m, output int unsigned y);
    int unsigned yy;
    int unsigned mm;
    yy = s / 366;
    while (year_start(yy + 1) <= s) begin
      yy++;
    end
    s -= year_start(yy);
    mm = 1;
    while ((mm < 12) && (s >= days_in_month(mm, yy))) begin
      s -= days_in_month(mm, yy);
      mm++;
    end
    d = s + 1;
    m = mm;
    y = yy;
  endfunction

  static function gda_out_t compute_date_result(gda_in_t r);
    gda_out_t    res;
    int unsigned s;
    int unsigned s2;
    int unsigned nd;
    int unsigned nm;
    int unsigned ny;
    bit          under;
    res.result_status  = ST_OK;
    res.result_day     = r.first_day;
    res.result_month   = r.first_month;
    res.result_year    = r.first_year;
    res.day_difference = '0;
    under = 1'b0;
    if (!real_date(r.first_day, r.first_month, r.first_year)) begin
      res.result_status = ST_FIRST_BAD;
    end else if ((r.req_type == OP_INC) || (r.req_type == OP_ADD) || (r.req_type == OP_SUB)) begin
      s = day_number(r.first_day, r.first_month, r.first_year);
      if (r.req_type == OP_INC) begin
        s += 1;
      end else if (r.req_type == OP_ADD) begin
        s += r.step_days;
      end else if (r.step_days > s) begin
        under = 1'b1;
      end else begin
        s -= r.step_days;
      end
      if (under) begin
        res.result_status = ST_RANGE;
      end else begin
        split_day_number(s, nd, nm, ny);
        if ((ny < 1) || (ny > MAX_YEAR_DEF)) begin
          res.result_status = ST_RANGE;
        end else begin
          res.result_day   = 5'(nd);
          res.result_month = 4'(nm);
          res.result_year  = 14'(ny);
        end
      end
    end else if (r.req_type == OP_DIFF) begin
      if (!real_date(r.second_day, r.second_month, r.second_year)) begin
        res.result_status = ST_SECOND_BAD;
      end else if ((r.first_year > MAX_YEAR_DEF) || (r.second_year > MAX_YEAR_DEF)) begin
        res.result_status = ST_RANGE;
      end else begin
        s  = day_number(r.first_day, r.first_month, r.first_year);
        s2 = day_number(r.second_day, r.second_month, r.second_year);
        if (s < s2) begin
          res.result_status = ST_EARLIER;
        end else if (s - s2 > DIFF_MAX) begin
          res.day_difference = DIFF_MAX;
        end else begin
          res.day_difference = DIFF_W'(s - s2);
        end
      end
    end
    return res;
  endfunction

  function void note_request(gda_in_t r);
    op_count[r.req_type]++;
    pending_results.push_back(compute_date_result(r));
  endfunction

  function void check_result(gda_out_t got);
    gda_out_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result with no request waiting: status %0d date %0d-%0d-%0d diff %0d",
                 got.result_status, got.result_year, got.result_month, got.result_day,
                 got.day_difference);
      end
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    status_count[want.result_status]++;
    if ((got.result_status !== want.result_status) || (got.result_day !== want.result_day) ||
        (got.result_month !== want.result_month) || (got.result_year !== want.result_year) ||
        (got.day_difference !== want.day_difference)) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on result %0d: expected status %0d date %0d-%0d-%0d diff %0d",
                 results_checked, want.result_status, want.result_year, want.result_month,
                 want.result_day, want.day_difference);
        $display("  got status %0d date %0d-%0d-%0d diff %0d", got.result_status,
                 got.result_year, got.result_month, got.result_day, got.day_difference);
      end
    end
  endfunction
endclass

module tb_gregorian_date_arithmetic_top;
  localparam logic [2:0]  OP_UNUSED_A  = 3'd5;
  localparam logic [2:0]  OP_UNUSED_B  = 3'd6;
  localparam logic [2:0]  OP_UNUSED_C  = 3'd7;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned STALL_LIMIT  = 8000;
  localparam int unsigned HOLD_AFTER   = 150;
  localparam int unsigned HOLD_CYCLES  = 1200;
  localparam int unsigned END_CYCLES   = 600;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  gda_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  gda_out_t out_data;

  date_scoreboard sb;
  int unsigned    idle_pct       = 0;
  int unsigned    results_taken  = 0;
  int unsigned    stall_left     = 0;
  int unsigned    hold_left      = 0;
  bit             hold_done      = 1'b0;

  gregorian_date_arithmetic_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: check each transfer, then pick next ready with bursts and one long hold
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      sb.check_result(out_data);
      results_taken++;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && (results_taken == HOLD_AFTER)) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ((idle_pct != 0) && ($urandom_range(0, 499) < idle_pct)) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int unsigned stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("tb_gregorian_date_arithmetic_top failed");
    $finish;
  end

  function automatic logic [13:0] random_year();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 14'($urandom_range(1, 9999));
    if (p < 65) return 14'($urandom_range(0, 4));
    if (p < 77) return 14'($urandom_range(9985, 9999));
    if (p < 87) return 14'($urandom_range(0, 99) * 100);
    if (p < 93) return 14'($urandom_range(1990, 2030));
    return 14'($urandom_range(10000, 16383));
  endfunction

  function automatic void spoil_date(inout logic [4:0] d, inout logic [3:0] m,
                                     input int unsigned y);
    int unsigned len;
    case ($urandom_range(0, 2))
      0: m = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
      1: d = 5'd0;
      default: begin
        len = sb.days_in_month(m, y);
        if (len < 31) begin
          d = 5'($urandom_range(len + 1, 31));
        end else begin
          m = 4'($urandom_range(13, 15));
        end
      end
    endcase
  endfunction

  function automatic gda_in_t random_request();
    gda_in_t     r;
    int unsigned p;
    int unsigned gap;
    p = $urandom_range(0, 99);
    if (p < 10)      r.req_type = OP_VALIDATE;
    else if (p < 22) r.req_type = OP_INC;
    else if (p < 44) r.req_type = OP_ADD;
    else if (p < 64) r.req_type = OP_SUB;
    else if (p < 92) r.req_type = OP_DIFF;
    else             r.req_type = 3'($urandom_range(OP_UNUSED_A, OP_UNUSED_C));
    r.first_year  = random_year();
    r.first_month = 4'($urandom_range(1, 12));
    r.first_day   = 5'($urandom_range(1,
                       sb.days_in_month(r.first_month, r.first_year)));
    if ($urandom_range(0, 99) < 8) begin
      spoil_date(r.first_day, r.first_month, r.first_year);
    end
    r.second_year  = 14'($urandom_range(0, 16383));
    r.second_month = 4'($urandom_range(0, 15));
    r.second_day   = 5'($urandom_range(0, 31));
    if (r.req_type == OP_DIFF) begin
      p = $urandom_range(0, 99);
      if (p < 10)      gap = 0;
      else if (p < 50) gap = $urandom_range(0, 3);
      else if (p < 80) gap = $urandom_range(0, 800);
      else             gap = $urandom_range(0, 16383);
      if (gap > r.first_year) gap = r.first_year;
      if (p < 95) begin
        r.second_year = r.first_year - 14'(gap);
      end else begin
        r.second_year = random_year();
      end
      r.second_month = 4'($urandom_range(1, 12));
      r.second_day   = 5'($urandom_range(1,
                         sb.days_in_month(r.second_month, r.second_year)));
      if (p < 10) begin
        r.second_month = r.first_month;
        r.second_day   = r.first_day;
      end
      if ($urandom_range(0, 99) < 6) begin
        spoil_date(r.second_day, r.second_month, r.second_year);
      end
    end
    p = $urandom_range(0, 99);
    if (p < 30)      r.step_days = 16'($urandom_range(0, 400));
    else if (p < 70) r.step_days = 16'($urandom);
    else if (p < 80) r.step_days = 16'hffff;
    else             r.step_days = 16'($urandom_range(0, 3000));
    return r;
  endfunction

  task automatic offer(input gda_in_t item);
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(item);
    if ((idle_pct != 0) && ($urandom_range(0, 99) < idle_pct)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic offer_dates(input logic [2:0] op, input int unsigned d1, input int unsigned m1,
                             input int unsigned y1, input int unsigned d2,
                             input int unsigned m2, input int unsigned y2,
                             input int unsigned n);
    gda_in_t r;
    r.req_type     = op;
    r.first_day    = 5'(d1);
    r.first_month  = 4'(m1);
    r.first_year   = 14'(y1);
    r.second_day   = 5'(d2);
    r.second_month = 4'(m2);
    r.second_year  = 14'(y2);
    r.step_days    = 16'(n);
    offer(r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    idle_pct = 20;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // leap rules, bad days and months, spare codes
    offer_dates(OP_VALIDATE, 29, 2, 2000, 0, 0, 0, 0);
    offer_dates(OP_VALIDATE, 29, 2, 1900, 31, 15, 16383, 65535);
    offer_dates(OP_VALIDATE, 0, 1, 2021, 1, 1, 1, 1);
    offer_dates(OP_VALIDATE, 31, 4, 2021, 1, 1, 1, 1);
    offer_dates(OP_VALIDATE, 31, 15, 16383, 31, 15, 16383, 65535);
    offer_dates(OP_VALIDATE, 29, 2, 0, 0, 0, 0, 0);
    offer_dates(OP_UNUSED_A, 31, 12, 9999, 1, 1, 1, 5);
    offer_dates(OP_UNUSED_B, 30, 2, 2020, 1, 1, 1, 5);
    offer_dates(OP_UNUSED_C, 1, 13, 1, 1, 1, 1, 5);
    // next day across month and year ends
    offer_dates(OP_INC, 30, 1, 2023, 0, 0, 0, 0);
    offer_dates(OP_INC, 28, 2, 2024, 0, 0, 0, 0);
    offer_dates(OP_INC, 31, 12, 2023, 0, 0, 0, 0);
    offer_dates(OP_INC, 31, 12, 9999, 0, 0, 0, 0);
    // add and subtract at the range limits
    offer_dates(OP_ADD, 15, 6, 1987, 0, 0, 0, 0);
    offer_dates(OP_ADD, 1, 1, 1, 0, 0, 0, 65535);
    offer_dates(OP_ADD, 1, 1, 9900, 0, 0, 0, 65535);
    offer_dates(OP_ADD, 31, 12, 0, 0, 0, 0, 1);
    offer_dates(OP_ADD, 1, 1, 12000, 0, 0, 0, 100);
    offer_dates(OP_SUB, 31, 12, 9999, 0, 0, 0, 65535);
    offer_dates(OP_SUB, 1, 1, 1, 0, 0, 0, 1);
    offer_dates(OP_SUB, 1, 1, 100, 0, 0, 0, 65535);
    // difference: widest span, year end landing, order and validity checks
    offer_dates(OP_DIFF, 31, 12, 9999, 1, 1, 0, 0);
    offer_dates(OP_DIFF, 31, 12, 2023, 1, 1, 2023, 0);
    offer_dates(OP_DIFF, 1, 1, 2000, 2, 1, 2000, 0);
    offer_dates(OP_DIFF, 5, 5, 2005, 5, 5, 2005, 0);
    offer_dates(OP_DIFF, 1, 1, 2000, 0, 13, 1999, 0);
    offer_dates(OP_DIFF, 0, 1, 2000, 0, 13, 1999, 0);
    offer_dates(OP_DIFF, 1, 1, 10000, 1, 1, 2000, 0);

    idle_pct = 30;
    repeat (250) offer(random_request());

    // sender pause until the block has returned everything
    wait_drained();

    idle_pct = 10;
    repeat (230) offer(random_request());

    idle_pct = 0;
    repeat (75) offer(random_request());

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);

    $display("checked %0d results: validate %0d, next day %0d, add %0d, subtract %0d, diff %0d, spare %0d",
             sb.results_checked, sb.op_count[OP_VALIDATE], sb.op_count[OP_INC],
             sb.op_count[OP_ADD], sb.op_count[OP_SUB], sb.op_count[OP_DIFF],
             sb.op_count[OP_UNUSED_A] + sb.op_count[OP_UNUSED_B] + sb.op_count[OP_UNUSED_C]);
    $display("statuses: ok %0d, first bad %0d, second bad %0d, range %0d, earlier %0d; errors %0d",
             sb.status_count[ST_OK], sb.status_count[ST_FIRST_BAD],
             sb.status_count[ST_SECOND_BAD], sb.status_count[ST_RANGE],
             sb.status_count[ST_EARLIER], sb.mismatches);
    if ((sb.mismatches == 0) && (sb.pending_results.size() == 0)) begin
      $display("tb_gregorian_date_arithmetic_top passed");
    end else begin
      $display("tb_gregorian_date_arithmetic_top failed");
    end
    $finish;
  end
endmodule
